// ===== design/rgb_to_gray_and_hsv_bin_assert.svh =====
// Assertion macros shared by the checker.
`ifndef RGB_TO_GRAY_AND_HSV_BIN_ASSERT_SVH
`define RGB_TO_GRAY_AND_HSV_BIN_ASSERT_SVH

// same-cycle implication, masked while in reset
`define RGBHSV_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while in reset
`define RGBHSV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// state in the cycle after reset is held
`define RGBHSV_ASSERT_RESET(label, cons, msg) \
    label: assert property (@(posedge aclk) !aresetn |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rgbhsv_pkg.sv =====
package rgbhsv_pkg;

    localparam int CHAN_W     = 8;
    localparam int S_DATA_W   = 3 * CHAN_W;
    localparam int M_DATA_W   = 2 * CHAN_W;
    localparam int SUM_W      = 18;
    localparam int NUM_W      = 11;
    localparam int BIN_W      = 3;
    localparam int RECIP_W    = 19;
    localparam int PROD_W     = SUM_W + RECIP_W;
    localparam int GRAY_SHIFT = 28;

    localparam logic [SUM_W-1:0]   W_RED      = SUM_W'(299);
    localparam logic [SUM_W-1:0]   W_GREEN    = SUM_W'(587);
    localparam logic [SUM_W-1:0]   W_BLUE     = SUM_W'(114);
    localparam logic [SUM_W-1:0]   GRAY_ROUND = SUM_W'(500);
    // ceil(2^GRAY_SHIFT / 1000), exact floor for every sum below 2^SUM_W
    localparam logic [RECIP_W-1:0] GRAY_RECIP = RECIP_W'(268436);

    localparam int BIN_MAX = 5;
    localparam logic [CHAN_W-1:0] VAL_UNIT = CHAN_W'(255);

    typedef logic [CHAN_W-1:0]   chan_t;
    typedef logic [NUM_W-1:0]    num_t;
    typedef logic [BIN_W-1:0]    bin_t;
    typedef logic [S_DATA_W-1:0] s_word_t;
    typedef logic [M_DATA_W-1:0] m_word_t;

endpackage

// ===== design/rgbhsv_quant.sv =====
module rgbhsv_quant (
    input  rgbhsv_pkg::num_t  num,
    input  rgbhsv_pkg::chan_t unit,
    output rgbhsv_pkg::bin_t  bin
);
    import rgbhsv_pkg::*;

    logic [BIN_MAX-1:0] hit;
    bin_t               count;

    // floor(num / unit) clamped to BIN_MAX, as a count of thresholds met
    always_comb begin
        count = '0;
        for (int k = 1; k <= BIN_MAX; k++) begin
            hit[k-1] = num >= NUM_W'(k) * NUM_W'(unit);
            count    = count + BIN_W'(hit[k-1]);
        end
    end

    assign bin = count;

endmodule

// ===== design/rgb_to_gray_and_hsv_bin.sv =====
// RGB pixel to luma gray and 216-bin HSV index. One pixel word enters per clock
// and its result leaves through a five-stage register pipeline
// (input, sums and extrema, numerators and luma product, bins, output); the
// sustained rate is one word per clock, reduced only by m_tready stalls, and
// empty stages are filled while the output waits. gray is round-half-up of
// (299r + 587g + 114b) / 1000; hsv_index is hue_bin + 6*sat_bin + 36*val_bin,
// each bin the exact floor of six times its component clamped to 5, with hue
// bin 0 for a gray pixel and saturation bin 0 for a black pixel.
module rgb_to_gray_and_hsv_bin (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  rgbhsv_pkg::s_word_t s_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic                m_tvalid,
    input  logic                m_tready,
    output rgbhsv_pkg::m_word_t m_tdata    // gray [7:0], hsv_index [15:8]
);
    import rgbhsv_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    chan_t r1_reg, g1_reg, b1_reg;

    logic [SUM_W-1:0] sum2_reg, sum2_next;
    chan_t            r2_reg, g2_reg, b2_reg;
    chan_t            mx2_reg, mx2_next, mn2_reg, mn2_next;

    logic [PROD_W-1:0] prod3_reg, prod3_next;
    num_t              num3_reg, num3_next, dsix3_reg, dsix3_next, vsix3_reg, vsix3_next;
    chan_t             d3_reg, d3_next, mx3_reg;

    chan_t gray4_reg;
    bin_t  hb4_reg, hb4_next, sb4_reg, sb4_next, vb4_reg;
    bin_t  hue_q, sat_q, val_q;

    chan_t gray5_reg, index5_reg, index5_next;

    assign rdy5     = !v5_reg || m_tready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign m_tvalid = v5_reg;
    assign m_tdata  = {index5_reg, gray5_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // stage 2: weighted sum and extrema
    always_comb begin
        sum2_next = SUM_W'(r1_reg) * W_RED + SUM_W'(g1_reg) * W_GREEN
                  + SUM_W'(b1_reg) * W_BLUE + GRAY_ROUND;
        mx2_next = r1_reg;
        if (g1_reg > mx2_next) mx2_next = g1_reg;
        if (b1_reg > mx2_next) mx2_next = b1_reg;
        mn2_next = r1_reg;
        if (g1_reg < mn2_next) mn2_next = g1_reg;
        if (b1_reg < mn2_next) mn2_next = b1_reg;
    end

    // stage 3: luma product, channel difference, and hue, saturation and value numerators
    always_comb begin
        prod3_next = PROD_W'(sum2_reg) * PROD_W'(GRAY_RECIP);
        d3_next    = mx2_reg - mn2_reg;
        dsix3_next = NUM_W'(d3_next) * NUM_W'(6);
        vsix3_next = NUM_W'(mx2_reg) * NUM_W'(6);
        priority if (r2_reg >= g2_reg && r2_reg >= b2_reg) begin
            if (g2_reg >= b2_reg) begin
                num3_next = NUM_W'(g2_reg) - NUM_W'(b2_reg);
            end else begin
                num3_next = dsix3_next - (NUM_W'(b2_reg) - NUM_W'(g2_reg));
            end
        end else if (g2_reg >= b2_reg) begin
            num3_next = (NUM_W'(d3_next) << 1) + NUM_W'(b2_reg) - NUM_W'(r2_reg);
        end else begin
            num3_next = (NUM_W'(d3_next) << 2) + NUM_W'(r2_reg) - NUM_W'(g2_reg);
        end
    end

    rgbhsv_quant u_hue (.num(num3_reg),  .unit(d3_reg),   .bin(hue_q));
    rgbhsv_quant u_sat (.num(dsix3_reg), .unit(mx3_reg),  .bin(sat_q));
    rgbhsv_quant u_val (.num(vsix3_reg), .unit(VAL_UNIT), .bin(val_q));

    assign hb4_next    = (d3_reg == '0) ? '0 : hue_q;
    assign sb4_next    = (mx3_reg == '0) ? '0 : sat_q;
    assign index5_next = CHAN_W'(hb4_reg) + CHAN_W'(sb4_reg) * CHAN_W'(6)
                       + CHAN_W'(vb4_reg) * CHAN_W'(36);

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            r1_reg <= s_tdata[CHAN_W-1:0];
            g1_reg <= s_tdata[2*CHAN_W-1:CHAN_W];
            b1_reg <= s_tdata[3*CHAN_W-1:2*CHAN_W];
        end
        if (rdy2) begin
            sum2_reg <= sum2_next;
            r2_reg   <= r1_reg;
            g2_reg   <= g1_reg;
            b2_reg   <= b1_reg;
            mx2_reg  <= mx2_next;
            mn2_reg  <= mn2_next;
        end
        if (rdy3) begin
            prod3_reg <= prod3_next;
            num3_reg  <= num3_next;
            dsix3_reg <= dsix3_next;
            vsix3_reg <= vsix3_next;
            d3_reg    <= d3_next;
            mx3_reg   <= mx2_reg;
        end
        if (rdy4) begin
            gray4_reg <= prod3_reg[GRAY_SHIFT+CHAN_W-1:GRAY_SHIFT];
            hb4_reg   <= hb4_next;
            sb4_reg   <= sb4_next;
            vb4_reg   <= val_q;
        end
        if (rdy5) begin
            gray5_reg  <= gray4_reg;
            index5_reg <= index5_next;
        end
    end

endmodule

// ===== design/rgbhsv_checker.sv =====
`include "rgb_to_gray_and_hsv_bin_assert.svh"

module rgbhsv_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input rgbhsv_pkg::m_word_t m_tdata
);
    import rgbhsv_pkg::*;

    logic in_word, out_stall, empty_idle, dark_word;
    chan_t out_gray, out_index;

    assign in_word    = s_tvalid && s_tready;
    assign out_gray   = m_tdata[CHAN_W-1:0];
    assign out_index  = m_tdata[2*CHAN_W-1:CHAN_W];
    assign out_stall  = m_tvalid && !m_tready;
    assign empty_idle = !in_word && !m_tvalid && s_tready;
    assign dark_word  = m_tvalid && out_index < 8'd36;

    `RGBHSV_ASSERT_RESET(a_reset_empty, s_tready && !m_tvalid, "pipeline not empty after reset")
    `RGBHSV_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata), "word changed in stall")
    `RGBHSV_ASSERT(a_index_range, m_tvalid, out_index <= 8'd215, "hsv_index out of range")
    `RGBHSV_ASSERT(a_dark_gray, dark_word, out_gray <= 8'd42, "gray above value bin zero")
    `RGBHSV_ASSERT_NEXT(a_empty_ready, empty_idle, s_tready, "ready dropped with empty output")

endmodule

bind rgb_to_gray_and_hsv_bin rgbhsv_checker u_rgbhsv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== bench/tb_top.sv =====
module tb_top;
    import rgbhsv_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int HOLD_CYCLES = 200;
    localparam int TAIL_CYCLES = 12;

    typedef struct packed {
        s_word_t pixel;
        chan_t   gray;
        chan_t   hsv_index;
    } pixel_result_t;

    logic    aclk     = 1'b0;
    logic    aresetn  = 1'b0;
    logic    s_tvalid = 1'b0;
    logic    s_tready;
    s_word_t s_tdata  = '0;
    logic    m_tvalid;
    logic    m_tready = 1'b0;
    m_word_t m_tdata;

    pixel_result_t result_q[$];
    pixel_result_t head;
    bit idle_on   = 1'b1;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stall_left = 0;
    int quiet     = 0;
    int errors    = 0;
    int n_sent    = 0;
    int n_checked = 0;

    rgb_to_gray_and_hsv_bin dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // red [7:0], green [15:8], blue [23:16]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // gray [7:0], hsv_index [15:8]
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int unsigned clamp_bin(int unsigned v);
        return (v > BIN_MAX) ? BIN_MAX : v;
    endfunction

    function automatic pixel_result_t predict_pixel(chan_t red, chan_t green, chan_t blue);
        pixel_result_t res;
        int unsigned r, g, b, mx, mn, d, num, hb, sb, vb;
        r = red;
        g = green;
        b = blue;
        mx = (r > g) ? r : g;
        mx = (b > mx) ? b : mx;
        mn = (r < g) ? r : g;
        mn = (b < mn) ? b : mn;
        d  = mx - mn;
        vb = clamp_bin((6 * mx) / 255);
        sb = (mx == 0) ? 0 : clamp_bin((6 * d) / mx);
        if (d == 0) begin
            hb = 0;
        end else begin
            if (r >= g && r >= b) begin
                num = (g >= b) ? (g - b) : (6 * d - (b - g));
            end else if (g >= b) begin
                num = 2 * d + b - r;
            end else begin
                num = 4 * d + r - g;
            end
            hb = clamp_bin(num / d);
        end
        res.pixel     = {blue, green, red};
        res.gray      = chan_t'((299 * r + 587 * g + 114 * b + 500) / 1000);
        res.hsv_index = chan_t'(hb + 6 * sb + 36 * vb);
        return res;
    endfunction

    task automatic send_pixel(chan_t red, chan_t green, chan_t blue);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= s_word_t'($urandom);
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {blue, green, red};
        do @(posedge aclk); while (!s_tready);
        result_q.push_back(predict_pixel(red, green, blue));
        n_sent++;
    endtask

    task automatic send_random_pixel();
        chan_t r, g, b;
        r = chan_t'($urandom);
        g = chan_t'($urandom);
        b = chan_t'($urandom);
        case ($urandom_range(0, 11))
            0: begin g = r; b = r; end
            1: g = r;
            2: b = g;
            3: r = b;
            4: r = 8'hFF;
            5: g = 8'h00;
            6: begin b = 8'hFF; r = 8'h00; end
            7: begin r = chan_t'($urandom_range(40, 45)); g = r; b = chan_t'($urandom_range(0, 45)); end
            default: ;
        endcase
        send_pixel(r, g, b);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1,   8'd1,   8'd1);
        send_pixel(8'd200, 8'd10,  8'd100);
        send_pixel(8'd200, 8'd100, 8'd10);
        send_pixel(8'd10,  8'd200, 8'd100);
        send_pixel(8'd100, 8'd200, 8'd10);
        send_pixel(8'd10,  8'd100, 8'd200);
        send_pixel(8'd100, 8'd10,  8'd200);
        send_pixel(8'd100, 8'd0,   8'd50);
        send_pixel(8'd42,  8'd42,  8'd42);
        send_pixel(8'd43,  8'd43,  8'd43);
        send_pixel(8'd0,   8'd0,   8'd250);
        send_pixel(8'd90,  8'd90,  8'd30);
        send_pixel(8'd30,  8'd90,  8'd90);
        send_pixel(8'd170, 8'd85,  8'd85);
        send_pixel(8'd254, 8'd1,   8'd127);
        wait_drained();
    endtask

    task automatic test_random_pixels(int count);
        repeat (count) send_random_pixel();
    endtask

    task automatic test_output_holdoff();
        hold_reqs++;
        repeat (60) send_random_pixel();
    endtask

    task automatic test_sender_drain();
        repeat (8) begin
            repeat ($urandom_range(1, 12)) send_random_pixel();
            wait_drained();
        end
    endtask

    task automatic test_full_rate(int count);
        idle_on = 1'b0;
        repeat (count) send_random_pixel();
    endtask

    // receiver: long hold-off on request, otherwise random stall bursts while idle_on is set
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_reqs) begin
            m_tready  <= 1'b0;
            hold_seen <= hold_seen + 1;
            hold_left <= HOLD_CYCLES - 1;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(1, 14) - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            n_checked++;
            if (result_q.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual %h", $time, m_tdata);
                errors++;
            end else begin
                head = result_q.pop_front();
                if (m_tdata[7:0] !== head.gray) begin
                    $display("%0t: gray mismatch for pixel %h: expected %0d, actual %0d",
                             $time, head.pixel, head.gray, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[15:8] !== head.hsv_index) begin
                    $display("%0t: hsv_index mismatch for pixel %h: expected %0d, actual %0d",
                             $time, head.pixel, head.hsv_index, m_tdata[15:8]);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, quiet);
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_pixels(700);
        test_output_holdoff();
        test_random_pixels(600);
        test_sender_drain();
        test_full_rate(400);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (result_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, result_q.size());
            errors += result_q.size();
        end
        $display("%0d pixels sent, %0d results checked: channel extremes, gray and black",
                 n_sent, n_checked);
        $display("pixels, all hue sectors, output hold-off, drained bursts and full rate");
        if (errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/rgbhsv_pkg.sv
design/rgbhsv_quant.sv
design/rgb_to_gray_and_hsv_bin.sv
design/rgbhsv_checker.sv
bench/tb_top.sv
